[src/yre_pkg.sv]
// ----------------------------------------------------------------------------
// yre_pkg
// Shared types, constants and arithmetic helpers of the yaw rate estimator
// and turn controller.
// ----------------------------------------------------------------------------
package yre_pkg;

    // request codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_SOFT   = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LINE_GAIN   = 3'd0;
    localparam logic [2:0] REG_TARGET_LIM  = 3'd1;
    localparam logic [2:0] REG_ALPHA       = 3'd2;
    localparam logic [2:0] REG_FF_GAIN     = 3'd3;
    localparam logic [2:0] REG_KP_GAIN     = 3'd4;
    localparam logic [2:0] REG_TURN_LIM    = 3'd5;
    localparam logic [2:0] REG_MAX_GAP     = 3'd6;
    localparam logic [2:0] REG_STALE       = 3'd7;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [15:0] RST_LINE_GAIN  = 16'd500;
    localparam logic [19:0] RST_TARGET_LIM = 20'd6000;
    localparam logic [15:0] RST_ALPHA      = 16'd22938;
    localparam logic [15:0] RST_FF_GAIN    = 16'd36045;
    localparam logic [15:0] RST_KP_GAIN    = 16'd9830;
    localparam logic [22:0] RST_TURN_LIM   = 23'd4000;
    localparam logic [15:0] RST_MAX_GAP    = 16'd100;
    localparam logic [15:0] RST_STALE      = 16'd150;

    // arithmetic constants
    localparam int WRAP_HALF    = 18000;
    localparam int WRAP_FULL    = 36000;
    localparam int RATE_MAX_ABS = 36000;
    localparam int RATE_PER_MS  = 36;
    localparam int MS_PER_S     = 1000;
    localparam int TARGET_SAT   = 1000000;
    localparam int DRIVE_MAX    = 8388607;
    localparam int DRIVE_MIN    = -8388608;

    // serial divider: quotient is known to fit in 16 bits
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int DIV_NUM_W = 25;

    // shared multiply-accumulate widths
    localparam int MAC_A_W = 17;
    localparam int MAC_B_W = 24;
    localparam int ACC_W   = 42;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [15:0] line_gain;
        logic [19:0] target_limit;
        logic [15:0] filter_alpha;
        logic [15:0] feedforward_gain;
        logic [15:0] proportional_gain;
        logic [22:0] turn_limit;
        logic [15:0] max_gap_ms;
        logic [15:0] stale_ms;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [15:0]          den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                      en;
        logic                      clr;
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
    } mac_req_t;

    // arithmetic shift right with rounding to nearest, ties away from zero
    function automatic acc_t round_shift(input acc_t value, input int unsigned shift);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        mag = value[ACC_W-1] ? ACC_W'(-value) : ACC_W'(value);
        q = (mag + (ACC_W'(1) << (shift - 1))) >> shift;
        return value[ACC_W-1] ? -acc_t'(q) : acc_t'(q);
    endfunction

    // clamp into [lo, hi]
    function automatic acc_t clamp_range(input acc_t value, input acc_t lo, input acc_t hi);
        acc_t res;
        res = value;
        if (value < lo)
        begin
            res = lo;
        end
        else if (value > hi)
        begin
            res = hi;
        end
        return res;
    endfunction

endpackage

[src/yre_cmd_if.sv]
// ----------------------------------------------------------------------------
// yre_cmd_if
// Request channel: one word per sample, update or soft reset request.
// ----------------------------------------------------------------------------
interface yre_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] yaw_angle;
    logic [31:0]        time_ms;
    logic signed [15:0] line_error;
    logic signed [16:0] rate_offset;
    logic               limits_on;

    modport source
    (
        output valid, req_type, yaw_angle, time_ms, line_error, rate_offset, limits_on,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, yaw_angle, time_ms, line_error, rate_offset, limits_on,
        output ready
    );
endinterface

[src/yre_rsp_if.sv]
// ----------------------------------------------------------------------------
// yre_rsp_if
// Result channel: one word per request with the controller state.
// ----------------------------------------------------------------------------
interface yre_rsp_if;
    logic               valid;
    logic               ready;
    logic               drive_ok;
    logic signed [20:0] target_rate;
    logic signed [16:0] measured_rate;
    logic signed [23:0] turn_drive;
    logic               rate_good;

    modport source
    (
        output valid, drive_ok, target_rate, measured_rate, turn_drive, rate_good,
        input  ready
    );

    modport sink
    (
        input  valid, drive_ok, target_rate, measured_rate, turn_drive, rate_good,
        output ready
    );
endinterface

[src/yre_cfg_regs.sv]
// ----------------------------------------------------------------------------
// yre_cfg_regs
// APB register file holding the gains, limits and timing thresholds.
// ----------------------------------------------------------------------------
module yre_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [yre_pkg::PADDR_W-1:0] paddr,
    input  logic [yre_pkg::PDATA_W-1:0] pwdata,
    output logic [yre_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output yre_pkg::cfg_t               cfg
);

    yre_pkg::cfg_t cfg_reg;
    yre_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                yre_pkg::REG_LINE_GAIN:  cfg_next.line_gain         = pwdata[15:0];
                yre_pkg::REG_TARGET_LIM: cfg_next.target_limit      = pwdata[19:0];
                yre_pkg::REG_ALPHA:      cfg_next.filter_alpha      = pwdata[15:0];
                yre_pkg::REG_FF_GAIN:    cfg_next.feedforward_gain  = pwdata[15:0];
                yre_pkg::REG_KP_GAIN:    cfg_next.proportional_gain = pwdata[15:0];
                yre_pkg::REG_TURN_LIM:   cfg_next.turn_limit        = pwdata[22:0];
                yre_pkg::REG_MAX_GAP:    cfg_next.max_gap_ms        = pwdata[15:0];
                yre_pkg::REG_STALE:      cfg_next.stale_ms          = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            yre_pkg::REG_LINE_GAIN:  prdata = 32'(cfg_reg.line_gain);
            yre_pkg::REG_TARGET_LIM: prdata = 32'(cfg_reg.target_limit);
            yre_pkg::REG_ALPHA:      prdata = 32'(cfg_reg.filter_alpha);
            yre_pkg::REG_FF_GAIN:    prdata = 32'(cfg_reg.feedforward_gain);
            yre_pkg::REG_KP_GAIN:    prdata = 32'(cfg_reg.proportional_gain);
            yre_pkg::REG_TURN_LIM:   prdata = 32'(cfg_reg.turn_limit);
            yre_pkg::REG_MAX_GAP:    prdata = 32'(cfg_reg.max_gap_ms);
            yre_pkg::REG_STALE:      prdata = 32'(cfg_reg.stale_ms);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_gain         <= yre_pkg::RST_LINE_GAIN;
            cfg_reg.target_limit      <= yre_pkg::RST_TARGET_LIM;
            cfg_reg.filter_alpha      <= yre_pkg::RST_ALPHA;
            cfg_reg.feedforward_gain  <= yre_pkg::RST_FF_GAIN;
            cfg_reg.proportional_gain <= yre_pkg::RST_KP_GAIN;
            cfg_reg.turn_limit        <= yre_pkg::RST_TURN_LIM;
            cfg_reg.max_gap_ms        <= yre_pkg::RST_MAX_GAP;
            cfg_reg.stale_ms          <= yre_pkg::RST_STALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/yre_divider.sv]
// ----------------------------------------------------------------------------
// yre_divider
// Restoring serial divider, one quotient bit per cycle, for quotients that
// fit in 16 bits.
// ----------------------------------------------------------------------------
module yre_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  yre_pkg::div_req_t req,
    output yre_pkg::div_rsp_t rsp
);

    logic [15:0]                    rem_reg, rem_next;
    logic [15:0]                    dvd_reg, dvd_next;
    logic [15:0]                    den_reg, den_next;
    logic [yre_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [16:0]                    trial;
    logic                           fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, dvd_reg[15]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // high dividend bits are already below the divisor
            rem_next = 16'(req.num[yre_pkg::DIV_NUM_W-1:16]);
            dvd_next = req.num[15:0];
            den_next = req.den;
            cnt_next = yre_pkg::DIV_CNT_W'(yre_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            dvd_next  = {dvd_reg[14:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = cnt_reg == yre_pkg::DIV_CNT_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
    end

endmodule

[src/yre_mac.sv]
// ----------------------------------------------------------------------------
// yre_mac
// Shared signed multiply-accumulate unit used for the filter step, the line
// gain product and the drive sum.
// ----------------------------------------------------------------------------
module yre_mac
(
    input  logic              clk,
    input  logic              rst_n,
    input  yre_pkg::mac_req_t req,
    output yre_pkg::acc_t     acc
);

    logic signed [yre_pkg::MAC_A_W-1:0]                 op_a;
    logic signed [yre_pkg::MAC_B_W-1:0]                 op_b;
    logic signed [yre_pkg::MAC_A_W+yre_pkg::MAC_B_W-1:0] prod;
    yre_pkg::acc_t                                      acc_reg, acc_next;

    assign op_a = req.a;
    assign op_b = req.b;
    assign prod = op_a * op_b;

    // accumulate, or start over on clear
    always_comb
    begin
        acc_next = acc_reg;
        if (req.en)
        begin
            acc_next = (req.clr ? yre_pkg::acc_t'(0) : acc_reg) + yre_pkg::acc_t'(prod);
        end
    end

    assign acc = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

[src/yaw_rate_estimate_and_turn_control.sv]
// ----------------------------------------------------------------------------
// yaw_rate_estimate_and_turn_control
// A yaw sample that is differentiated passes through the 16-step serial
// divider and the filter step; an update passes through the shared
// multiply-accumulate unit; other requests go straight to the result word.
// One request at a time: the next word is taken once the result is registered.
// Reset: rst_n clears all controller state and loads the register defaults.
// ----------------------------------------------------------------------------
module yaw_rate_estimate_and_turn_control
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [yre_pkg::PADDR_W-1:0] paddr,
    input  logic [yre_pkg::PDATA_W-1:0] pwdata,
    output logic [yre_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    yre_cmd_if.sink                     cmd,
    yre_rsp_if.source                   rsp
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SAMPLE = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_FMUL   = 4'd4;
    localparam logic [3:0] ST_FUPD   = 4'd5;
    localparam logic [3:0] ST_TMUL   = 4'd6;
    localparam logic [3:0] ST_TARGET = 4'd7;
    localparam logic [3:0] ST_FFMUL  = 4'd8;
    localparam logic [3:0] ST_KPMUL  = 4'd9;
    localparam logic [3:0] ST_DRIVE  = 4'd10;
    localparam logic [3:0] ST_CLEAR  = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    yre_pkg::cfg_t     cfg;
    yre_pkg::div_req_t div_req;
    yre_pkg::div_rsp_t div_rsp;
    yre_pkg::mac_req_t mac_req;
    yre_pkg::acc_t     mac_acc;

    logic [3:0]         state_reg, state_next;

    // latched request word
    logic [1:0]         req_reg, req_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic [31:0]        time_reg, time_next;
    logic signed [15:0] err_reg, err_next;
    logic signed [16:0] off_reg, off_next;
    logic               lim_reg, lim_next;

    // controller state
    logic signed [15:0] prev_head_reg, prev_head_next;
    logic [31:0]        prev_stamp_reg, prev_stamp_next;
    logic [31:0]        latest_stamp_reg, latest_stamp_next;
    logic signed [16:0] filt_reg, filt_next;
    logic signed [20:0] target_reg, target_next;
    logic signed [23:0] drive_reg, drive_next;
    logic               have_prev_reg, have_prev_next;
    logic               valid_reg, valid_next;
    logic               ok_reg, ok_next;

    // working values
    logic signed [15:0] delta_reg, delta_next;
    logic [15:0]        elapsed_reg, elapsed_next;
    logic signed [16:0] raw_reg, raw_next;

    // output word
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic signed [20:0] out_target_reg, out_target_next;
    logic signed [16:0] out_rate_reg, out_rate_next;
    logic signed [23:0] out_drive_reg, out_drive_next;
    logic               out_good_reg, out_good_next;

    logic [31:0]        elapsed_full;
    logic [31:0]        age;
    logic signed [17:0] wrap0, wrap1, wrap2;
    logic [14:0]        delta_mag;
    logic [21:0]        rate_bound;
    logic signed [16:0] raw_val;
    yre_pkg::acc_t      step_val, filt_sum;
    yre_pkg::acc_t      tgt_raw, tgt_lim, tgt_val;
    yre_pkg::acc_t      drv_raw, drv_lim, drv_val;

    // one heading wrap correction
    function automatic logic signed [17:0] wrap_fix(input logic signed [17:0] v);
        logic signed [17:0] res;
        res = v;
        if (v > yre_pkg::WRAP_HALF)
        begin
            res = 18'(v - yre_pkg::WRAP_FULL);
        end
        else if (v < -yre_pkg::WRAP_HALF)
        begin
            res = 18'(v + yre_pkg::WRAP_FULL);
        end
        return res;
    endfunction

    yre_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    yre_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    yre_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .acc   (mac_acc)
    );

    // sample path arithmetic
    assign elapsed_full = time_reg - prev_stamp_reg;
    assign age          = time_reg - latest_stamp_reg;
    assign wrap0        = 18'(yaw_reg) - 18'(prev_head_reg);
    assign wrap1        = wrap_fix(wrap0);
    assign wrap2        = wrap_fix(wrap1);
    assign delta_mag    = delta_reg[15] ? 15'(-delta_reg) : 15'(delta_reg);
    assign rate_bound   = 22'(elapsed_reg) * 22'(yre_pkg::RATE_PER_MS);
    assign raw_val      = delta_reg[15] ? -$signed({1'b0, div_rsp.quot})
                                        :  $signed({1'b0, div_rsp.quot});

    // filter step from the accumulator
    assign step_val = yre_pkg::round_shift(mac_acc, 16);
    assign filt_sum = yre_pkg::clamp_range(yre_pkg::acc_t'(filt_reg) + step_val,
                                           -yre_pkg::acc_t'(yre_pkg::RATE_MAX_ABS),
                                           yre_pkg::acc_t'(yre_pkg::RATE_MAX_ABS));

    // target from the line error product
    assign tgt_raw = yre_pkg::acc_t'(off_reg) - yre_pkg::round_shift(mac_acc, 8);
    assign tgt_lim = lim_reg ? yre_pkg::clamp_range(tgt_raw,
                                   -yre_pkg::acc_t'(cfg.target_limit),
                                   yre_pkg::acc_t'(cfg.target_limit))
                             : tgt_raw;
    assign tgt_val = yre_pkg::clamp_range(tgt_lim,
                                          -yre_pkg::acc_t'(yre_pkg::TARGET_SAT),
                                          yre_pkg::acc_t'(yre_pkg::TARGET_SAT));

    // drive from the feedforward plus proportional sum
    assign drv_raw = yre_pkg::round_shift(mac_acc, 16);
    assign drv_lim = lim_reg ? yre_pkg::clamp_range(drv_raw,
                                   -yre_pkg::acc_t'(cfg.turn_limit),
                                   yre_pkg::acc_t'(cfg.turn_limit))
                             : drv_raw;
    assign drv_val = yre_pkg::clamp_range(drv_lim,
                                          yre_pkg::acc_t'(yre_pkg::DRIVE_MIN),
                                          yre_pkg::acc_t'(yre_pkg::DRIVE_MAX));

    // divider launch
    always_comb
    begin
        div_req.start = (state_reg == ST_CHECK) && !(22'(delta_mag) > rate_bound);
        div_req.num   = yre_pkg::DIV_NUM_W'(delta_mag) * yre_pkg::DIV_NUM_W'(yre_pkg::MS_PER_S)
                      + yre_pkg::DIV_NUM_W'(elapsed_reg >> 1);
        div_req.den   = elapsed_reg;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mac_req.en  = 1'b0;
        mac_req.clr = 1'b1;
        mac_req.a   = '0;
        mac_req.b   = '0;
        case (state_reg)
            ST_FMUL:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = {1'b0, cfg.filter_alpha};
                mac_req.b  = 24'(raw_reg) - 24'(filt_reg);
            end
            ST_TMUL:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = {1'b0, cfg.line_gain};
                mac_req.b  = 24'(err_reg);
            end
            ST_FFMUL:
            begin
                mac_req.en = 1'b1;
                mac_req.a  = {1'b0, cfg.feedforward_gain};
                mac_req.b  = 24'(target_reg);
            end
            ST_KPMUL:
            begin
                mac_req.en  = 1'b1;
                mac_req.clr = 1'b0;
                mac_req.a   = {1'b0, cfg.proportional_gain};
                mac_req.b   = 24'(target_reg) - 24'(filt_reg);
            end
            default:
            begin
                mac_req.en = 1'b0;
            end
        endcase
    end

    assign cmd.ready = state_reg == ST_IDLE;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        yaw_next          = yaw_reg;
        time_next         = time_reg;
        err_next          = err_reg;
        off_next          = off_reg;
        lim_next          = lim_reg;
        prev_head_next    = prev_head_reg;
        prev_stamp_next   = prev_stamp_reg;
        latest_stamp_next = latest_stamp_reg;
        filt_next         = filt_reg;
        target_next       = target_reg;
        drive_next        = drive_reg;
        have_prev_next    = have_prev_reg;
        valid_next        = valid_reg;
        ok_next           = ok_reg;
        delta_next        = delta_reg;
        elapsed_next      = elapsed_reg;
        raw_next          = raw_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_ok_next       = out_ok_reg;
        out_target_next   = out_target_reg;
        out_rate_next     = out_rate_reg;
        out_drive_next    = out_drive_reg;
        out_good_next     = out_good_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    req_next  = cmd.req_type;
                    yaw_next  = cmd.yaw_angle;
                    time_next = cmd.time_ms;
                    err_next  = cmd.line_error;
                    off_next  = cmd.rate_offset;
                    lim_next  = cmd.limits_on;
                    case (cmd.req_type)
                        yre_pkg::REQ_SAMPLE: state_next = ST_SAMPLE;
                        yre_pkg::REQ_UPDATE: state_next = ST_TMUL;
                        yre_pkg::REQ_SOFT:   state_next = ST_CLEAR;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end

            // gap checks and heading wrap
            ST_SAMPLE:
            begin
                latest_stamp_next = time_reg;
                state_next        = ST_DONE;
                if (!have_prev_reg)
                begin
                    prev_head_next  = yaw_reg;
                    prev_stamp_next = time_reg;
                    have_prev_next  = 1'b1;
                    valid_next      = 1'b0;
                end
                else if (elapsed_full == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (elapsed_full > 32'(cfg.max_gap_ms))
                begin
                    prev_head_next  = yaw_reg;
                    prev_stamp_next = time_reg;
                    filt_next       = '0;
                    valid_next      = 1'b0;
                end
                else
                begin
                    delta_next      = 16'(wrap2);
                    elapsed_next    = elapsed_full[15:0];
                    prev_head_next  = yaw_reg;
                    prev_stamp_next = time_reg;
                    state_next      = ST_CHECK;
                end
            end

            // impossible rate test, else divide
            ST_CHECK:
            begin
                if (22'(delta_mag) > rate_bound)
                begin
                    filt_next  = '0;
                    valid_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    raw_next = raw_val;
                    if (valid_reg)
                    begin
                        state_next = ST_FMUL;
                    end
                    else
                    begin
                        filt_next  = raw_val;
                        valid_next = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_FMUL:
            begin
                state_next = ST_FUPD;
            end

            ST_FUPD:
            begin
                filt_next  = 17'(filt_sum);
                valid_next = 1'b1;
                state_next = ST_DONE;
            end

            ST_TMUL:
            begin
                state_next = ST_TARGET;
            end

            // store target, then stale check
            ST_TARGET:
            begin
                target_next = 21'(tgt_val);
                if (!valid_reg || (age > 32'(cfg.stale_ms)))
                begin
                    filt_next  = '0;
                    drive_next = '0;
                    valid_next = 1'b0;
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FFMUL;
                end
            end

            ST_FFMUL:
            begin
                state_next = ST_KPMUL;
            end

            ST_KPMUL:
            begin
                state_next = ST_DRIVE;
            end

            ST_DRIVE:
            begin
                drive_next = 24'(drv_val);
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end

            ST_CLEAR:
            begin
                prev_head_next    = '0;
                prev_stamp_next   = '0;
                latest_stamp_next = '0;
                filt_next         = '0;
                target_next       = '0;
                drive_next        = '0;
                have_prev_next    = 1'b0;
                valid_next        = 1'b0;
                state_next        = ST_DONE;
            end

            // load the result word once the output register is free
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_ok_next     = (req_reg == yre_pkg::REQ_UPDATE) ? ok_reg : valid_reg;
                    out_target_next = target_reg;
                    out_rate_next   = filt_reg;
                    out_drive_next  = drive_reg;
                    out_good_next   = valid_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.drive_ok      = out_ok_reg;
    assign rsp.target_rate   = out_target_reg;
    assign rsp.measured_rate = out_rate_reg;
    assign rsp.turn_drive    = out_drive_reg;
    assign rsp.rate_good     = out_good_reg;

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prev_head_reg    <= '0;
            prev_stamp_reg   <= '0;
            latest_stamp_reg <= '0;
            filt_reg         <= '0;
            target_reg       <= '0;
            drive_reg        <= '0;
            have_prev_reg    <= 1'b0;
            valid_reg        <= 1'b0;
            ok_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_head_reg    <= prev_head_next;
            prev_stamp_reg   <= prev_stamp_next;
            latest_stamp_reg <= latest_stamp_next;
            filt_reg         <= filt_next;
            target_reg       <= target_next;
            drive_reg        <= drive_next;
            have_prev_reg    <= have_prev_next;
            valid_reg        <= valid_next;
            ok_reg           <= ok_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        yaw_reg        <= yaw_next;
        time_reg       <= time_next;
        err_reg        <= err_next;
        off_reg        <= off_next;
        lim_reg        <= lim_next;
        delta_reg      <= delta_next;
        elapsed_reg    <= elapsed_next;
        raw_reg        <= raw_next;
        out_ok_reg     <= out_ok_next;
        out_target_reg <= out_target_next;
        out_rate_reg   <= out_rate_next;
        out_drive_reg  <= out_drive_next;
        out_good_reg   <= out_good_next;
    end

`ifndef SYNTHESIS
    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // a valid rate always has a reference sample behind it
    a_valid_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> have_prev_reg)
        else $error("rate valid without previous sample");

    // filtered rate stays inside the physical bound
    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (filt_reg <= 17'sd36000) && (filt_reg >= -17'sd36000))
        else $error("filtered rate out of range");

    // a finished request waits while the output word is stalled
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && !rsp.ready) |=> (state_reg == ST_DONE))
        else $error("result lost under output stall");
`endif

endmodule

[test/turn_control_checker.sv]
// ----------------------------------------------------------------------------
// turn_control_checker
// Watches the request, result and register ports of the yaw rate estimator.
// Keeps its own copy of the settings and of the controller state, works out
// the result word of every accepted request and compares each returned word
// field by field with the oldest word still due.
// ----------------------------------------------------------------------------
module turn_control_checker
    import yre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    yre_cmd_if                 cmd,
    yre_rsp_if                 rsp,
    output int                 mismatches,
    output int                 outstanding
);

    localparam longint HALF_TURN  = 18000;
    localparam longint FULL_TURN  = 36000;
    localparam longint RATE_LIMIT = 36000;
    localparam longint TARGET_CAP = 1000000;
    localparam longint DRIVE_HI   = 8388607;
    localparam longint DRIVE_LO   = -8388608;
    localparam longint Q16        = 65536;

    typedef struct packed {
        logic               drive_ok;
        logic signed [20:0] target_rate;
        logic signed [16:0] measured_rate;
        logic signed [23:0] turn_drive;
        logic               rate_good;
    } turn_word_t;

    // settings copy
    logic [15:0] k_line;
    logic [19:0] k_target_cap;
    logic [15:0] k_alpha;
    logic [15:0] k_ff;
    logic [15:0] k_kp;
    logic [22:0] k_turn_cap;
    logic [15:0] k_gap;
    logic [15:0] k_stale;

    // controller state copy
    logic signed [15:0] last_heading;
    logic [31:0]        last_stamp;
    logic [31:0]        newest_stamp;
    longint             rate_est;
    longint             target_hold;
    longint             drive_hold;
    bit                 have_heading;
    bit                 rate_ok;

    turn_word_t words_due[$];
    int         bad_words;
    int         words_seen;

    // divide with rounding to nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void load_defaults();
        k_line       = 16'd500;
        k_target_cap = 20'd6000;
        k_alpha      = 16'd22938;
        k_ff         = 16'd36045;
        k_kp         = 16'd9830;
        k_turn_cap   = 23'd4000;
        k_gap        = 16'd100;
        k_stale      = 16'd150;
    endfunction

    function automatic void clear_controller();
        last_heading = '0;
        last_stamp   = '0;
        newest_stamp = '0;
        rate_est     = 0;
        target_hold  = 0;
        drive_hold   = 0;
        have_heading = 1'b0;
        rate_ok      = 1'b0;
    endfunction

    function automatic void write_setting(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_LINE_GAIN:  k_line       = value[15:0];
            REG_TARGET_LIM: k_target_cap = value[19:0];
            REG_ALPHA:      k_alpha      = value[15:0];
            REG_FF_GAIN:    k_ff         = value[15:0];
            REG_KP_GAIN:    k_kp         = value[15:0];
            REG_TURN_LIM:   k_turn_cap   = value[22:0];
            REG_MAX_GAP:    k_gap        = value[15:0];
            REG_STALE:      k_stale      = value[15:0];
            default:        ;
        endcase
    endfunction

    // differentiate the heading and smooth the rate
    function automatic void take_heading_sample(input logic signed [15:0] yaw,
                                                input logic [31:0] now);
        logic [31:0] elapsed;
        longint      delta;
        longint      mag;
        longint      raw;
        longint      step;
        newest_stamp = now;
        if (!have_heading)
        begin
            last_heading = yaw;
            last_stamp   = now;
            have_heading = 1'b1;
            rate_ok      = 1'b0;
            return;
        end
        elapsed = now - last_stamp;
        if (elapsed == 0)
        begin
            return;
        end
        // too long since the last heading: start over from this one
        if (elapsed > 32'(k_gap))
        begin
            last_heading = yaw;
            last_stamp   = now;
            rate_est     = 0;
            rate_ok      = 1'b0;
            return;
        end
        delta = longint'(yaw) - longint'(last_heading);
        while (delta > HALF_TURN)
        begin
            delta -= FULL_TURN;
        end
        while (delta < -HALF_TURN)
        begin
            delta += FULL_TURN;
        end
        last_heading = yaw;
        last_stamp   = now;
        // physically impossible turn rate
        mag = (delta < 0) ? -delta : delta;
        if (mag * 1000 > RATE_LIMIT * longint'(elapsed))
        begin
            rate_est = 0;
            rate_ok  = 1'b0;
            return;
        end
        raw = round_div(delta * 1000, longint'(elapsed));
        if (!rate_ok)
        begin
            rate_est = raw;
        end
        else
        begin
            step = round_div(longint'(k_alpha) * (raw - rate_est), Q16);
            rate_est = clip(rate_est + step, -RATE_LIMIT, RATE_LIMIT);
        end
        rate_ok = 1'b1;
    endfunction

    // target rate and feedforward plus proportional drive
    function automatic bit run_turn_update(input logic signed [15:0] err,
                                           input logic signed [16:0] off,
                                           input logic [31:0] now,
                                           input logic lim);
        longint      t;
        longint      d;
        logic [31:0] age;
        t = -round_div(longint'(k_line) * longint'(err), 256) + longint'(off);
        if (lim)
        begin
            t = clip(t, -longint'(k_target_cap), longint'(k_target_cap));
        end
        t = clip(t, -TARGET_CAP, TARGET_CAP);
        target_hold = t;
        age = now - newest_stamp;
        if (!rate_ok || age > 32'(k_stale))
        begin
            rate_est   = 0;
            drive_hold = 0;
            rate_ok    = 1'b0;
            return 1'b0;
        end
        d = longint'(k_ff) * t + longint'(k_kp) * (t - rate_est);
        d = round_div(d, Q16);
        if (lim)
        begin
            d = clip(d, -longint'(k_turn_cap), longint'(k_turn_cap));
        end
        drive_hold = clip(d, DRIVE_LO, DRIVE_HI);
        return 1'b1;
    endfunction

    function automatic turn_word_t predict_word(input logic [1:0] kind,
                                                input logic signed [15:0] yaw,
                                                input logic [31:0] now,
                                                input logic signed [15:0] err,
                                                input logic signed [16:0] off,
                                                input logic lim);
        turn_word_t w;
        bit         ok;
        case (kind)
            REQ_SAMPLE:
            begin
                take_heading_sample(yaw, now);
                ok = rate_ok;
            end
            REQ_UPDATE:
            begin
                ok = run_turn_update(err, off, now, lim);
            end
            REQ_SOFT:
            begin
                clear_controller();
                ok = rate_ok;
            end
            default:
            begin
                ok = rate_ok;
            end
        endcase
        w.drive_ok      = ok;
        w.target_rate   = 21'(target_hold);
        w.measured_rate = 17'(rate_est);
        w.turn_drive    = 24'(drive_hold);
        w.rate_good     = rate_ok;
        return w;
    endfunction

    // compare one returned word with the oldest one due
    function automatic void check_word();
        turn_word_t got;
        turn_word_t want;
        got = {rsp.drive_ok, rsp.target_rate, rsp.measured_rate, rsp.turn_drive, rsp.rate_good};
        words_seen++;
        if (words_due.size() == 0)
        begin
            bad_words++;
            if (bad_words <= 10)
            begin
                $display("word %0d returned with none due", words_seen);
            end
            return;
        end
        want = words_due.pop_front();
        if (got !== want)
        begin
            bad_words++;
            if (bad_words <= 10)
            begin
                $display(
                    "word %0d ok/target/rate/drive/good want %0b/%0d/%0d/%0d/%0b got %0b/%0d/%0d/%0d/%0b",
                    words_seen, want.drive_ok, want.target_rate, want.measured_rate,
                    want.turn_drive, want.rate_good, got.drive_ok, got.target_rate,
                    got.measured_rate, got.turn_drive, got.rate_good);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_defaults();
            clear_controller();
            words_due.delete();
            bad_words   = 0;
            words_seen  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                write_setting(paddr[PADDR_W-1:2], pwdata);
            end
            // a result word can never belong to a request taken on the same edge
            if (rsp.valid && rsp.ready)
            begin
                check_word();
            end
            if (cmd.valid && cmd.ready)
            begin
                words_due.push_back(predict_word(cmd.req_type, cmd.yaw_angle, cmd.time_ms,
                                                 cmd.line_error, cmd.rate_offset,
                                                 cmd.limits_on));
            end
            outstanding <= words_due.size();
            mismatches  <= bad_words;
        end
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Regression of the yaw rate estimator and turn controller: a directed run
// through the corner cases of sampling and control, then random request
// streams under several register settings and handshake pacing schemes,
// checked word by word by turn_control_checker.
// ----------------------------------------------------------------------------
module testbench;
    import yre_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         HOLD_CYCLES   = 300;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 mismatches;
    int                 outstanding;
    int                 idle_pct;
    int                 stall_pct;
    bit                 hold_req;
    int                 cur_gap;
    int                 cur_stale;
    logic signed [15:0] heading;
    logic [31:0]        stamp;
    logic [31:0]        reg_plan [0:7];

    yre_cmd_if cmd_ch ();
    yre_rsp_if rsp_ch ();

    yaw_rate_estimate_and_turn_control i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch)
    );

    turn_control_checker i_turn_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("yaw_rate_estimate_and_turn_control regression: fail");
        $finish;
    end

    // offer one request word, idling before it at the current rate
    task automatic offer(input logic [1:0] kind, input logic signed [15:0] yaw,
                         input logic [31:0] ms, input logic signed [15:0] err,
                         input logic signed [16:0] off, input logic lim);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.req_type    <= kind;
        cmd_ch.yaw_angle   <= yaw;
        cmd_ch.time_ms     <= ms;
        cmd_ch.line_error  <= err;
        cmd_ch.rate_offset <= off;
        cmd_ch.limits_on   <= lim;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
    endtask

    // stop offering and wait until every word due has come back
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers from reg_plan
    task automatic program_regs();
        for (int i = 0; i < 8; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'(i * 4);
            pwdata  <= reg_plan[i];
            @(posedge clk);
            penable <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!pready);
        end
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_gap   = int'(reg_plan[REG_MAX_GAP]);
        cur_stale = int'(reg_plan[REG_STALE]);
        @(posedge clk);
    endtask

    task automatic plan_random_regs();
        reg_plan[REG_LINE_GAIN]  = $urandom_range(3000);
        reg_plan[REG_TARGET_LIM] = $urandom_range(1000000);
        reg_plan[REG_ALPHA]      = $urandom_range(65535);
        reg_plan[REG_FF_GAIN]    = $urandom_range(65535);
        reg_plan[REG_KP_GAIN]    = $urandom_range(65535);
        reg_plan[REG_TURN_LIM]   = $urandom_range(300000);
        reg_plan[REG_MAX_GAP]    = $urandom_range(150, 1);
        reg_plan[REG_STALE]      = $urandom_range(200);
    endtask

    // mostly plausible heading tracks and fresh updates, some broken words
    task automatic random_item();
        int                 pick;
        int                 span;
        int                 el;
        int                 d;
        int                 h;
        logic [31:0]        r1;
        logic [31:0]        r2;
        logic [31:0]        r3;
        logic [31:0]        ms;
        logic signed [15:0] err;
        logic signed [16:0] off;
        pick = $urandom_range(99);
        r1   = $urandom;
        r2   = $urandom;
        r3   = $urandom;
        err  = r3[15:0];
        off  = r3[31:15];
        if (pick < 55)
        begin
            // heading step within the physical rate limit
            span = (cur_gap == 0) ? 5 : ((cur_gap > 60) ? 60 : cur_gap);
            el = $urandom_range(span, 1);
            d = int'($urandom_range(72 * el)) - 36 * el;
            h = int'(heading) + d;
            if (h > 18000)
            begin
                h -= 36000;
            end
            else if (h < -18000)
            begin
                h += 36000;
            end
            heading = 16'(h);
            stamp += 32'(el);
            offer(REQ_SAMPLE, heading, stamp, err, off, r1[31]);
        end
        else if (pick < 85)
        begin
            // update, mostly fresh, sometimes right at or past the stale age
            if ($urandom_range(9) == 0)
            begin
                ms = stamp + 32'(cur_stale) + $urandom_range(2);
            end
            else
            begin
                ms = stamp + $urandom_range((cur_stale > 40) ? 40 : cur_stale);
            end
            if (r2[20])
            begin
                err = 16'(int'($urandom_range(4096)) - 2048);
            end
            if (r2[21])
            begin
                off = 17'(int'($urandom_range(4000)) - 2000);
            end
            offer(REQ_UPDATE, r1[15:0], ms, err, off, r1[30]);
        end
        else if (pick < 90)
        begin
            // repeated stamp
            offer(REQ_SAMPLE, r1[15:0], stamp, err, off, r1[31]);
        end
        else if (pick < 94)
        begin
            // gap too long, or a jump anywhere on the time line
            if (r2[31])
            begin
                stamp = r1;
            end
            else
            begin
                stamp += 32'(cur_gap) + $urandom_range(50, 1);
            end
            heading = 16'(int'($urandom_range(36000)) - 18000);
            offer(REQ_SAMPLE, heading, stamp, err, off, r2[30]);
        end
        else if (pick < 97)
        begin
            // any heading at all, usually an impossible rate
            heading = r1[15:0];
            stamp += $urandom_range(3, 1);
            offer(REQ_SAMPLE, heading, stamp, err, off, r2[30]);
        end
        else if (pick < 99)
        begin
            offer(REQ_SOFT, r1[15:0], r2, err, off, r1[31]);
        end
        else
        begin
            offer(REQ_UNUSED, r1[15:0], r2, err, off, r1[31]);
        end
    endtask

    task automatic run_phase(input int n_items, input int idle, input int stall,
                             input bit squeeze);
        idle_pct  = idle;
        stall_pct = stall;
        if (squeeze)
        begin
            hold_req = 1'b1;
        end
        repeat (n_items) random_item();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.req_type    <= REQ_SAMPLE;
        cmd_ch.yaw_angle   <= '0;
        cmd_ch.time_ms     <= '0;
        cmd_ch.line_error  <= '0;
        cmd_ch.rate_offset <= '0;
        cmd_ch.limits_on   <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        cur_gap   = 100;
        cur_stale = 150;
        heading   = '0;
        stamp     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases under the reset settings
        offer(REQ_UNUSED, '1, '1, '1, '1, 1'b1);
        offer(REQ_UPDATE, '0, '0, '0, '0, 1'b0);
        stamp = 32'hFFFF_FFF0;
        offer(REQ_SAMPLE, 16'sd17900, stamp, '0, '0, 1'b0);
        offer(REQ_SAMPLE, -16'sd500, stamp, '0, '0, 1'b0);
        // heading wrap upward, then downward
        stamp += 10;
        offer(REQ_SAMPLE, -16'sd17950, stamp, '0, '0, 1'b0);
        stamp += 10;
        offer(REQ_SAMPLE, 16'sd17990, stamp, '0, '0, 1'b0);
        // impossible rate just after the time stamp wrap
        stamp += 10;
        offer(REQ_SAMPLE, 16'sd17000, stamp, '0, '0, 1'b0);
        stamp += 10;
        offer(REQ_SAMPLE, 16'sd17100, stamp, '0, '0, 1'b0);
        // exactly the rate limit, then a rounding tie
        stamp += 10;
        offer(REQ_SAMPLE, 16'sd17460, stamp, '0, '0, 1'b0);
        stamp += 16;
        offer(REQ_SAMPLE, 16'sd17459, stamp, '0, '0, 1'b0);
        // target extremes, stale age boundary
        offer(REQ_UPDATE, '0, stamp, 16'sh7FFF, '0, 1'b1);
        offer(REQ_UPDATE, '0, stamp, 16'sh8000, 17'sh0FFFF, 1'b0);
        offer(REQ_UPDATE, '0, stamp + 150, '0, 17'sh10000, 1'b1);
        offer(REQ_UPDATE, '0, stamp + 151, 16'sd256, '0, 1'b0);
        stamp += 5;
        offer(REQ_SAMPLE, 16'sd17400, stamp, '0, '0, 1'b0);
        // one past the largest gap, then exactly the largest gap
        stamp += 101;
        offer(REQ_SAMPLE, '0, stamp, '0, '0, 1'b0);
        stamp += 100;
        offer(REQ_SAMPLE, 16'sd3600, stamp, '0, '0, 1'b0);
        // headings outside the stated range
        stamp += 100;
        offer(REQ_SAMPLE, 16'sh8000, stamp, '0, '0, 1'b0);
        stamp += 100;
        offer(REQ_SAMPLE, 16'sh7FFF, stamp, '0, '0, 1'b0);
        offer(REQ_UPDATE, '0, stamp, 16'sd100, 17'sd1000, 1'b1);
        stamp += 1;
        offer(REQ_SAMPLE, 16'sd32737, stamp, '0, '0, 1'b0);
        offer(REQ_UPDATE, '0, stamp + 3, -16'sd200, -17'sd500, 1'b1);
        // soft reset keeps the settings
        offer(REQ_SOFT, '1, '1, '1, '1, 1'b1);
        offer(REQ_UPDATE, '0, stamp, '0, '0, 1'b0);
        offer(REQ_SAMPLE, '0, stamp, '0, '0, 1'b0);
        heading = '0;

        run_phase(300, 0, 0, 1'b0);

        // every register at its top value
        settle();
        reg_plan[REG_LINE_GAIN]  = 32'hFFFF;
        reg_plan[REG_TARGET_LIM] = 32'hF_FFFF;
        reg_plan[REG_ALPHA]      = 32'hFFFF;
        reg_plan[REG_FF_GAIN]    = 32'hFFFF;
        reg_plan[REG_KP_GAIN]    = 32'hFFFF;
        reg_plan[REG_TURN_LIM]   = 32'h7F_FFFF;
        reg_plan[REG_MAX_GAP]    = 32'hFFFF;
        reg_plan[REG_STALE]      = 32'hFFFF;
        program_regs();
        run_phase(250, 81, 0, 1'b0);

        // every register at zero: no step is ever differentiated
        settle();
        for (int i = 0; i < 8; i++)
        begin
            reg_plan[i] = '0;
        end
        program_regs();
        run_phase(100, 0, 81, 1'b0);

        settle();
        plan_random_regs();
        program_regs();
        run_phase(300, 31, 31, 1'b0);

        // reset settings again, input kept busy through a long result hold-off
        settle();
        reg_plan[REG_LINE_GAIN]  = 32'd500;
        reg_plan[REG_TARGET_LIM] = 32'd6000;
        reg_plan[REG_ALPHA]      = 32'd22938;
        reg_plan[REG_FF_GAIN]    = 32'd36045;
        reg_plan[REG_KP_GAIN]    = 32'd9830;
        reg_plan[REG_TURN_LIM]   = 32'd4000;
        reg_plan[REG_MAX_GAP]    = 32'd100;
        reg_plan[REG_STALE]      = 32'd150;
        program_regs();
        run_phase(300, 0, 0, 1'b1);

        settle();
        plan_random_regs();
        program_regs();
        run_phase(300, 0, 81, 1'b0);

        settle();
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("yaw_rate_estimate_and_turn_control regression: pass");
        end
        else
        begin
            $display("yaw_rate_estimate_and_turn_control regression: fail");
        end
        $finish;
    end

endmodule
